/* rtl/cole_pkg.sv */
// shared constants, codes and control bundles for the circular ordered list engine
// no dependencies; used by every file of the block
package cole_pkg;

  // default node memory depth
  localparam int DEF_CAPACITY = 32;

  // field widths fixed by the interface
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // node memory strobes
  typedef struct packed {
    logic rd_en;
    logic wr_val_en;
    logic wr_link_en;
  } mem_ctl_t;

  // slot occupancy strobes
  typedef struct packed {
    logic set_en;
    logic clr_en;
  } slot_ctl_t;

endpackage

/* rtl/cole_node_mem.sv */
// node memory: value and link of every slot, one write address and one read address
// depends on cole_pkg for mem_ctl_t
module cole_node_mem #(
  parameter int SLOTS = cole_pkg::DEF_CAPACITY,
  parameter int SW    = $clog2(SLOTS)
) (
  input  logic                          clk,
  input  cole_pkg::mem_ctl_t            ctl,
  input  logic [SW-1:0]                 rd_addr,
  input  logic [SW-1:0]                 wr_addr,
  input  logic [cole_pkg::VALUE_W-1:0]  wr_val,
  input  logic [SW-1:0]                 wr_link,
  output logic [cole_pkg::VALUE_W-1:0]  rd_val,
  output logic [SW-1:0]                 rd_link
);

  logic [cole_pkg::VALUE_W-1:0] val_mem  [SLOTS];
  logic [SW-1:0]                link_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.wr_val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (ctl.wr_link_en) begin
      link_mem[wr_addr] <= wr_link;
    end
  end

  // registered read, data in the cycle after the address
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_val  <= val_mem[rd_addr];
      rd_link <= link_mem[rd_addr];
    end
  end

endmodule

/* rtl/cole_slot_map.sv */
// slot occupancy flags, cleared by reset, with one free/used probe
// depends on cole_pkg for slot_ctl_t
module cole_slot_map #(
  parameter int SLOTS = cole_pkg::DEF_CAPACITY,
  parameter int SW    = $clog2(SLOTS)
) (
  input  logic               clk,
  input  logic               rst,
  input  cole_pkg::slot_ctl_t ctl,
  input  logic [SW-1:0]      set_idx,
  input  logic [SW-1:0]      clr_idx,
  input  logic [SW-1:0]      query_idx,
  output logic               query_free
);

  logic [SLOTS-1:0] in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      if (ctl.set_en) begin
        in_use[set_idx] <= 1'b1;
      end
      if (ctl.clr_en) begin
        in_use[clr_idx] <= 1'b0;
      end
    end
  end

  assign query_free = !in_use[query_idx];

endmodule

/* rtl/circular_ordered_list_engine_core.sv */
// top level of the circular ordered list engine: command sequencer and pointers
// depends on cole_pkg, cole_node_mem and cole_slot_map
//
// a bounded ordered list of signed 32-bit values held as a ring of linked slots.
// a command beat is taken when start is high and busy is low; busy then stays
// high until the command is finished. each result beat is shown for exactly one
// cycle with result_strobe high and cannot be held off, so the receiver must
// take it in that cycle. append, insert and remove give one result beat; a dump
// gives one beat per element in list order, on back-to-back cycles, with
// last_of_run on the final one (an empty list dumps a single status-empty beat).
// busy time grows with the lowest free slot index for append and insert, with the
// insert position for a mid-list insert, with the index of the match for a remove
// hit and with the element count for a miss or a dump. it comes from the node
// memory: one read per cycle while the ring is walked, with registered read
// data, and one probe per cycle while the lowest free slot is found. full and
// empty cases hold busy for a single cycle. the result beat lands in the cycle
// after the last busy cycle. the longest case at the default depth of 32 is a
// mid-list insert at position 31 with slot 31 the only free one.
module circular_ordered_list_engine_core #(
  parameter int LIST_CAPACITY = cole_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [cole_pkg::CMD_W-1:0]          command,
  input  logic signed [cole_pkg::VALUE_W-1:0] element_value,
  input  logic [cole_pkg::POS_W-1:0]          position,
  output logic                                result_strobe,
  output logic [cole_pkg::STATUS_W-1:0]       status,
  output logic signed [cole_pkg::VALUE_W-1:0] entry_value,
  output logic [cole_pkg::COUNT_W-1:0]        entry_count,
  output logic                                last_of_run
);

  // slot index, element count and step counter widths
  localparam int SW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int CW = $clog2(LIST_CAPACITY + 1);
  localparam int XW = (CW > cole_pkg::POS_W) ? CW : cole_pkg::POS_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(LIST_CAPACITY);

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DECIDE    = 9'b000000010,
    S_SCAN      = 9'b000000100,
    S_PLACE     = 9'b000001000,
    S_WALK_INS  = 9'b000010000,
    S_LINK_PREV = 9'b000100000,
    S_WALK_RM   = 9'b001000000,
    S_DUMP      = 9'b010000000,
    S_SPARE     = 9'b100000000
  } state_t;

  state_t state, state_next;

  // list pointers and count
  logic [SW-1:0] first_slot, first_slot_next;
  logic [SW-1:0] last_slot, last_slot_next;
  logic [CW-1:0] held_count, held_count_next;

  // latched command beat
  logic [cole_pkg::CMD_W-1:0]   cmd, cmd_next;
  logic [cole_pkg::VALUE_W-1:0] arg_value, arg_value_next;
  logic [cole_pkg::POS_W-1:0]   arg_pos, arg_pos_next;

  // walk registers
  logic [SW-1:0] prev, prev_next;
  logic [SW-1:0] cur, cur_next;
  logic [SW-1:0] nslot, nslot_next;
  logic [XW-1:0] step, step_next;

  // result registers
  logic                          strobe_next;
  logic [cole_pkg::STATUS_W-1:0] status_next;
  logic [cole_pkg::VALUE_W-1:0]  value_next;
  logic [cole_pkg::COUNT_W-1:0]  count_next;
  logic                          last_next;

  // memory and slot map hookup
  cole_pkg::mem_ctl_t           mem_ctl;
  logic [SW-1:0]                mem_rd_addr;
  logic [SW-1:0]                mem_wr_addr;
  logic [cole_pkg::VALUE_W-1:0] mem_wr_val;
  logic [SW-1:0]                mem_wr_link;
  logic [cole_pkg::VALUE_W-1:0] mem_rd_val;
  logic [SW-1:0]                mem_rd_link;
  cole_pkg::slot_ctl_t          slot_ctl;
  logic                         slot_free;

  // shared compare terms
  logic [XW-1:0] pos_x;
  logic [XW-1:0] count_x;
  logic [XW-1:0] step_inc;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;
  logic          at_last_step;
  logic          to_head;
  logic          to_mid;

  // result load helpers
  logic                          emit;
  logic [cole_pkg::STATUS_W-1:0] e_status;
  logic [cole_pkg::VALUE_W-1:0]  e_value;
  logic [CW-1:0]                 e_count;
  logic                          e_last;
  logic [XW-1:0]                 e_count_x;

  cole_node_mem #(
    .SLOTS (LIST_CAPACITY),
    .SW    (SW)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_val  (mem_wr_val),
    .wr_link (mem_wr_link),
    .rd_val  (mem_rd_val),
    .rd_link (mem_rd_link)
  );

  cole_slot_map #(
    .SLOTS (LIST_CAPACITY),
    .SW    (SW)
  ) u_slots (
    .clk        (clk),
    .rst        (rst),
    .ctl        (slot_ctl),
    .set_idx    (nslot),
    .clr_idx    (cur),
    .query_idx  (nslot),
    .query_free (slot_free)
  );

  assign busy = (state != S_IDLE);

  assign pos_x        = XW'(arg_pos);
  assign count_x      = XW'(held_count);
  assign step_inc     = step + XW'(1);
  assign count_inc    = held_count + CW'(1);
  assign count_dec    = held_count - CW'(1);
  assign at_last_step = (step_inc == count_x);
  // insert at the head when the position is at most one or the list is empty
  assign to_head = (cmd == cole_pkg::CMD_INSERT) &&
                   ((arg_pos <= cole_pkg::POS_W'(1)) || (held_count == '0));
  // mid-list insert when the position lies within the list, otherwise append
  assign to_mid  = (cmd == cole_pkg::CMD_INSERT) && !to_head && (pos_x <= count_x);

  always_comb begin
    state_next      = state;
    first_slot_next = first_slot;
    last_slot_next  = last_slot;
    held_count_next = held_count;
    cmd_next        = cmd;
    arg_value_next  = arg_value;
    arg_pos_next    = arg_pos;
    prev_next       = prev;
    cur_next        = cur;
    nslot_next      = nslot;
    step_next       = step;

    mem_ctl     = '0;
    mem_rd_addr = cur;
    mem_wr_addr = nslot;
    mem_wr_val  = arg_value;
    mem_wr_link = first_slot;
    slot_ctl    = '0;

    emit     = 1'b0;
    e_status = cole_pkg::ST_OK;
    e_value  = '0;
    e_count  = held_count;
    e_last   = 1'b1;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next       = command;
          arg_value_next = element_value;
          arg_pos_next   = position;
          state_next     = S_DECIDE;
        end
      end

      S_DECIDE: begin
        case (cmd)
          cole_pkg::CMD_APPEND, cole_pkg::CMD_INSERT: begin
            if (held_count == FULL_COUNT) begin
              emit       = 1'b1;
              e_status   = cole_pkg::ST_FULL;
              state_next = S_IDLE;
            end else begin
              nslot_next = '0;
              state_next = S_SCAN;
            end
          end
          cole_pkg::CMD_REMOVE, cole_pkg::CMD_DUMP: begin
            if (held_count == '0) begin
              emit       = 1'b1;
              e_status   = cole_pkg::ST_EMPTY;
              state_next = S_IDLE;
            end else begin
              // fetch the head; the walk starts with the tail as predecessor
              mem_ctl.rd_en = 1'b1;
              mem_rd_addr   = first_slot;
              cur_next      = first_slot;
              prev_next     = last_slot;
              step_next     = '0;
              state_next    = (cmd == cole_pkg::CMD_DUMP) ? S_DUMP : S_WALK_RM;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      // one slot probed per cycle, lowest index first
      S_SCAN: begin
        if (slot_free) begin
          state_next = S_PLACE;
        end else begin
          nslot_next = nslot + SW'(1);
        end
      end

      S_PLACE: begin
        slot_ctl.set_en = 1'b1;
        if (to_mid) begin
          // walk from the head to the slot before the position
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = first_slot;
          prev_next     = first_slot;
          step_next     = XW'(2);
          state_next    = S_WALK_INS;
        end else begin
          // head and tail placement write the same links, only the pointers differ
          mem_ctl.wr_val_en  = 1'b1;
          mem_ctl.wr_link_en = 1'b1;
          mem_wr_addr        = nslot;
          mem_wr_link        = (held_count == '0) ? nslot : first_slot;
          prev_next          = last_slot;
          if (to_head) begin
            first_slot_next = nslot;
            if (held_count == '0) begin
              last_slot_next = nslot;
            end
          end else begin
            last_slot_next = nslot;
            if (held_count == '0) begin
              first_slot_next = nslot;
            end
          end
          if (held_count == '0) begin
            held_count_next = count_inc;
            emit            = 1'b1;
            e_count         = count_inc;
            state_next      = S_IDLE;
          end else begin
            state_next = S_LINK_PREV;
          end
        end
      end

      S_WALK_INS: begin
        if (step < pos_x) begin
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = mem_rd_link;
          prev_next     = mem_rd_link;
          step_next     = step_inc;
        end else begin
          // new node takes over the successor of prev
          mem_ctl.wr_val_en  = 1'b1;
          mem_ctl.wr_link_en = 1'b1;
          mem_wr_addr        = nslot;
          mem_wr_link        = mem_rd_link;
          state_next         = S_LINK_PREV;
        end
      end

      // close the chain: prev now points at the new node
      S_LINK_PREV: begin
        mem_ctl.wr_link_en = 1'b1;
        mem_wr_addr        = prev;
        mem_wr_link        = nslot;
        held_count_next    = count_inc;
        emit               = 1'b1;
        e_count            = count_inc;
        state_next         = S_IDLE;
      end

      S_WALK_RM: begin
        if (mem_rd_val == arg_value) begin
          slot_ctl.clr_en = 1'b1;
          held_count_next = count_dec;
          emit            = 1'b1;
          e_count         = count_dec;
          state_next      = S_IDLE;
          if (held_count == CW'(1)) begin
            // sole element gone, pointers back to reset
            first_slot_next = '0;
            last_slot_next  = '0;
          end else begin
            mem_ctl.wr_link_en = 1'b1;
            mem_wr_addr        = prev;
            mem_wr_link        = mem_rd_link;
            if (cur == first_slot) begin
              first_slot_next = mem_rd_link;
            end
            if (cur == last_slot) begin
              last_slot_next = prev;
            end
          end
        end else if (at_last_step) begin
          emit       = 1'b1;
          e_status   = cole_pkg::ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = mem_rd_link;
          prev_next     = cur;
          cur_next      = mem_rd_link;
          step_next     = step_inc;
        end
      end

      // one element per cycle, next read issued alongside
      S_DUMP: begin
        emit    = 1'b1;
        e_value = mem_rd_val;
        e_last  = at_last_step;
        if (at_last_step) begin
          state_next = S_IDLE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = mem_rd_link;
          cur_next      = mem_rd_link;
          step_next     = step_inc;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // count masked to the width of the result field
  assign e_count_x   = XW'(e_count);
  assign strobe_next = emit;
  assign status_next = e_status;
  assign value_next  = emit ? e_value : '0;
  assign count_next  = e_count_x[cole_pkg::COUNT_W-1:0];
  assign last_next   = e_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_slot    <= '0;
      last_slot     <= '0;
      held_count    <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      first_slot    <= first_slot_next;
      last_slot     <= last_slot_next;
      held_count    <= held_count_next;
      result_strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd       <= cmd_next;
    arg_value <= arg_value_next;
    arg_pos   <= arg_pos_next;
    prev      <= prev_next;
    cur       <= cur_next;
    nslot     <= nslot_next;
    step      <= step_next;
    if (emit) begin
      status      <= status_next;
      entry_value <= value_next;
      entry_count <= count_next;
      last_of_run <= last_next;
    end
  end

  // count never passes the node memory depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= FULL_COUNT)
    else $error("element count beyond capacity");

  // a run of result beats is unbroken until its last beat
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_of_run |=> result_strobe)
    else $error("gap inside a dump run");

  // an accepted command beat holds busy on the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after command beat");

  // no result beat while a command is still being taken
  a_no_result_idle_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> !result_strobe)
    else $error("result beat with no command in flight");

endmodule

/* dv/cole_result_checker.sv */
// result checker for the circular ordered list engine: keeps its own copy of the ring,
// works out the beats each accepted command should give and compares them as they come
// depends on cole_pkg
module cole_result_checker #(
  parameter int CAPACITY = cole_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic [cole_pkg::CMD_W-1:0]          command,
  input  logic signed [cole_pkg::VALUE_W-1:0] element_value,
  input  logic [cole_pkg::POS_W-1:0]          position,
  input  logic                                result_strobe,
  input  logic [cole_pkg::STATUS_W-1:0]       status,
  input  logic signed [cole_pkg::VALUE_W-1:0] entry_value,
  input  logic [cole_pkg::COUNT_W-1:0]        entry_count,
  input  logic                                last_of_run,
  output int                                  failures,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef struct packed {
    logic [cole_pkg::STATUS_W-1:0] status;
    logic [cole_pkg::VALUE_W-1:0]  value;
    logic [cole_pkg::COUNT_W-1:0]  count;
    logic                          last;
  } beat_t;

  beat_t awaited_beats[$];

  // shadow of the ring
  logic [cole_pkg::VALUE_W-1:0] slot_val  [CAPACITY];
  logic [IDX_W-1:0]             slot_next [CAPACITY];
  bit                           slot_taken[CAPACITY];
  logic [IDX_W-1:0]             head_slot;
  logic [IDX_W-1:0]             tail_slot;
  int unsigned                  held;

  int fail_total = 0;
  assign failures = fail_total;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_total++;
  endtask

  task automatic clear_list();
    for (int i = 0; i < CAPACITY; i++) begin
      slot_taken[i] = 1'b0;
      slot_val[i]   = '0;
      slot_next[i]  = '0;
    end
    head_slot = '0;
    tail_slot = '0;
    held      = 0;
    awaited_beats.delete();
  endtask

  task automatic await_beat(input logic [cole_pkg::STATUS_W-1:0] st,
                            input logic [cole_pkg::VALUE_W-1:0] v,
                            input logic last);
    beat_t b;
    b.status = st;
    b.value  = v;
    b.count  = cole_pkg::COUNT_W'(held);
    b.last   = last;
    awaited_beats.push_back(b);
  endtask

  // lowest free slot; callers make sure one is free
  task automatic claim_slot(input logic [cole_pkg::VALUE_W-1:0] v,
                            output logic [IDX_W-1:0] slot);
    int idx;
    idx = 0;
    while (idx < CAPACITY - 1 && slot_taken[idx]) idx++;
    slot_taken[idx] = 1'b1;
    slot_val[idx]   = v;
    slot = IDX_W'(idx);
  endtask

  task automatic push_tail(input logic [cole_pkg::VALUE_W-1:0] v);
    logic [IDX_W-1:0] n;
    claim_slot(v, n);
    if (held == 0) begin
      head_slot = n;
      slot_next[n] = n;
    end else begin
      slot_next[tail_slot] = n;
      slot_next[n] = head_slot;
    end
    tail_slot = n;
    held++;
  endtask

  task automatic push_head(input logic [cole_pkg::VALUE_W-1:0] v);
    logic [IDX_W-1:0] n;
    claim_slot(v, n);
    if (held == 0) begin
      tail_slot = n;
      slot_next[n] = n;
    end else begin
      slot_next[n] = head_slot;
      slot_next[tail_slot] = n;
    end
    head_slot = n;
    held++;
  endtask

  task automatic place_at(input logic [cole_pkg::VALUE_W-1:0] v,
                          input logic [cole_pkg::POS_W-1:0] pos);
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] n;
    if (pos <= 1 || held == 0) begin
      push_head(v);
    end else if (int'(pos) > held) begin
      push_tail(v);
    end else begin
      prev = head_slot;
      for (int i = 2; i < int'(pos); i++) prev = slot_next[prev];
      claim_slot(v, n);
      slot_next[n] = slot_next[prev];
      slot_next[prev] = n;
      held++;
    end
  endtask

  task automatic take_out(input logic [cole_pkg::VALUE_W-1:0] v,
                          output logic [cole_pkg::STATUS_W-1:0] st);
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] nxt;
    bit hit;
    st = cole_pkg::ST_NOT_FOUND;
    if (held == 0) begin
      st = cole_pkg::ST_EMPTY;
      return;
    end
    prev = tail_slot;
    cur  = head_slot;
    hit  = 1'b0;
    for (int i = 0; i < held && !hit; i++) begin
      if (slot_val[cur] == v) begin
        hit = 1'b1;
        st  = cole_pkg::ST_OK;
        nxt = slot_next[cur];
        slot_taken[cur] = 1'b0;
        held--;
        if (held == 0) begin
          head_slot = '0;
          tail_slot = '0;
        end else begin
          slot_next[prev] = nxt;
          if (cur == head_slot) head_slot = nxt;
          if (cur == tail_slot) tail_slot = prev;
        end
      end else begin
        prev = cur;
        cur  = slot_next[cur];
      end
    end
  endtask

  task automatic list_step(input logic [cole_pkg::CMD_W-1:0] cmd,
                           input logic [cole_pkg::VALUE_W-1:0] v,
                           input logic [cole_pkg::POS_W-1:0] pos);
    logic [cole_pkg::STATUS_W-1:0] st;
    logic [IDX_W-1:0]              cur;
    case (cmd)
      cole_pkg::CMD_APPEND, cole_pkg::CMD_INSERT: begin
        st = cole_pkg::ST_FULL;
        if (held < CAPACITY) begin
          if (cmd == cole_pkg::CMD_APPEND) push_tail(v);
          else place_at(v, pos);
          st = cole_pkg::ST_OK;
        end
        await_beat(st, '0, 1'b1);
      end
      cole_pkg::CMD_REMOVE: begin
        take_out(v, st);
        await_beat(st, '0, 1'b1);
      end
      default: begin
        if (held == 0) begin
          await_beat(cole_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          cur = head_slot;
          for (int i = 0; i < held; i++) begin
            await_beat(cole_pkg::ST_OK, slot_val[cur], (i + 1 == held));
            cur = slot_next[cur];
          end
        end
      end
    endcase
  endtask

  task automatic check_result_beat();
    beat_t want;
    if (awaited_beats.size() == 0) begin
      report_mismatch($sformatf("result beat with none outstanding (status %0d value %0d)",
                                status, entry_value));
      return;
    end
    want = awaited_beats.pop_front();
    if (status !== want.status)
      report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
    if (entry_value !== want.value)
      report_mismatch($sformatf("entry_value %0d, wanted %0d", entry_value,
                                $signed(want.value)));
    if (entry_count !== want.count)
      report_mismatch($sformatf("entry_count %0d, wanted %0d", entry_count, want.count));
    if (last_of_run !== want.last)
      report_mismatch($sformatf("last_of_run %0b, wanted %0b", last_of_run, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_list();
    end else begin
      // results first: a new command's beats never land on its own accept edge
      if (result_strobe !== 1'b0) check_result_beat();
      if (start === 1'b1 && busy === 1'b0) list_step(command, element_value, position);
    end
    pending <= awaited_beats.size();
  end

endmodule

/* dv/testbench.sv */
// top of the list engine testbench: clock, reset, command stimulus and the verdict
// depends on cole_pkg, circular_ordered_list_engine_core and cole_result_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = cole_pkg::DEF_CAPACITY;
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 60;      // longer than a full dump plus its setup

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic [cole_pkg::CMD_W-1:0]          command = cole_pkg::CMD_APPEND;
  logic signed [cole_pkg::VALUE_W-1:0] element_value = '0;
  logic [cole_pkg::POS_W-1:0]          position = '0;
  logic                                busy;
  logic                                result_strobe;
  logic [cole_pkg::STATUS_W-1:0]       status;
  logic signed [cole_pkg::VALUE_W-1:0] entry_value;
  logic [cole_pkg::COUNT_W-1:0]        entry_count;
  logic                                last_of_run;
  int                                  failures;
  int                                  pending;

  // sender idling, percent of cycles, set per phase
  int idle_pct = 0;
  int cycle_count = 0;

  // values that commands are drawn from, so removes find matches and duplicates occur
  logic [cole_pkg::VALUE_W-1:0] value_pool[12];

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  circular_ordered_list_engine_core #(
    .LIST_CAPACITY(CAPACITY)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .element_value (element_value),
    .position      (position),
    .result_strobe (result_strobe),
    .status        (status),
    .entry_value   (entry_value),
    .entry_count   (entry_count),
    .last_of_run   (last_of_run)
  );

  cole_result_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .element_value (element_value),
    .position      (position),
    .result_strobe (result_strobe),
    .status        (status),
    .entry_value   (entry_value),
    .entry_count   (entry_count),
    .last_of_run   (last_of_run),
    .failures      (failures),
    .pending       (pending)
  );

  // watchdog: a hung engine or a lost beat ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one command beat: optional idle cycles, then hold start until busy is low at an edge
  task automatic send_command(input logic [cole_pkg::CMD_W-1:0] cmd,
                              input logic [cole_pkg::VALUE_W-1:0] v,
                              input logic [cole_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    command       <= cmd;
    element_value <= v;
    position      <= pos;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  function automatic logic [cole_pkg::VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 85) return value_pool[$urandom_range(11)];
    return $urandom;
  endfunction

  // half small positions so mid-list inserts are common; a quarter span the field, a quarter lie in 12 to 36
  function automatic logic [cole_pkg::POS_W-1:0] pick_position();
    case ($urandom_range(3))
      0:       return cole_pkg::POS_W'($urandom_range(63));
      1:       return cole_pkg::POS_W'($urandom_range(12, 36));
      default: return cole_pkg::POS_W'($urandom_range(8));
    endcase
  endfunction

  // remove and dump shares per phase; what is left splits between append and insert
  task automatic random_commands(input int count, input int remove_pct, input int dump_pct);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < remove_pct)
        send_command(cole_pkg::CMD_REMOVE, pick_value(), pick_position());
      else if (r < remove_pct + dump_pct)
        send_command(cole_pkg::CMD_DUMP, $urandom, pick_position());
      else if ($urandom_range(1) == 0)
        send_command(cole_pkg::CMD_APPEND, pick_value(), pick_position());
      else
        send_command(cole_pkg::CMD_INSERT, pick_value(), pick_position());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, head/tail/mid inserts, removes at every spot, extremes
    send_command(cole_pkg::CMD_DUMP,   32'h0000_0000, 6'd0);   // dump of an empty list
    send_command(cole_pkg::CMD_REMOVE, 32'h0000_0005, 6'd0);   // remove from an empty list
    send_command(cole_pkg::CMD_INSERT, 32'h7fff_ffff, 6'd63);  // insert into an empty list
    send_command(cole_pkg::CMD_APPEND, 32'h8000_0000, 6'd0);
    send_command(cole_pkg::CMD_INSERT, 32'hffff_ffff, 6'd0);   // head, position zero
    send_command(cole_pkg::CMD_INSERT, 32'h0000_0000, 6'd1);   // head, position one
    send_command(cole_pkg::CMD_INSERT, 32'h0000_0001, 6'd40);  // past the end, tail moves
    send_command(cole_pkg::CMD_INSERT, 32'h5555_5555, 6'd3);   // mid-list
    send_command(cole_pkg::CMD_APPEND, 32'haaaa_aaaa, 6'd0);
    send_command(cole_pkg::CMD_DUMP,   32'h0000_0000, 6'd0);
    send_command(cole_pkg::CMD_REMOVE, 32'h0001_2345, 6'd0);   // no match
    send_command(cole_pkg::CMD_REMOVE, 32'h0000_0000, 6'd0);   // head
    send_command(cole_pkg::CMD_REMOVE, 32'haaaa_aaaa, 6'd0);   // tail
    send_command(cole_pkg::CMD_REMOVE, 32'h5555_5555, 6'd0);   // mid-list
    send_command(cole_pkg::CMD_APPEND, 32'h7fff_ffff, 6'd0);   // duplicate value
    send_command(cole_pkg::CMD_REMOVE, 32'h7fff_ffff, 6'd0);   // only the first match goes
    send_command(cole_pkg::CMD_DUMP,   32'h0000_0000, 6'd0);
    send_command(cole_pkg::CMD_REMOVE, 32'h8000_0000, 6'd0);
    send_command(cole_pkg::CMD_REMOVE, 32'h0000_0001, 6'd0);
    send_command(cole_pkg::CMD_REMOVE, 32'hffff_ffff, 6'd0);
    send_command(cole_pkg::CMD_REMOVE, 32'h7fff_ffff, 6'd0);   // sole element
    send_command(cole_pkg::CMD_DUMP,   32'h0000_0000, 6'd0);
    send_command(cole_pkg::CMD_INSERT, 32'h0000_002a, 6'd2);   // empty list, position past one

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 12; i++) value_pool[i] = $urandom;

    // grow to full with no idling, so full status shows up
    idle_pct = 0;
    random_commands(60, 10, 10);
    // shrink with a mostly idle sender
    idle_pct = 86;
    random_commands(50, 70, 10);
    // grow again back to back
    idle_pct = 0;
    random_commands(50, 10, 10);
    // even mix with light idling
    idle_pct = 7;
    random_commands(50, 25, 25);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // catch any stray beats after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
